### hw/rtl/esc_pkg.sv
package esc_pkg;

	// Cycles from the pressure path's input to its result register, and the
	// same for the humidity path. The top level evens them out.
	localparam int PRESS_LAT = 78;
	localparam int HUM_LAT   = 9;

	localparam logic [63:0] P_OFFS   = 64'h0000_8000_0000_0000;
	localparam logic [31:0] HUM_CLIP = 32'd419430400;
	localparam logic [16:0] HUM_MAX  = 17'd102400;

	typedef enum logic [2:0] {
		REG_CAL_TEMP    = 3'd0,
		REG_CAL_PRESS_A = 3'd1,
		REG_CAL_PRESS_B = 3'd2,
		REG_CAL_PRESS_C = 3'd3,
		REG_CAL_HUM_A   = 3'd4,
		REG_CAL_HUM_B   = 3'd5,
		REG_PRESS_EN    = 3'd6,
		REG_HUM_EN      = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
		logic [7:0]  h1;
		logic [15:0] h2;
		logic [7:0]  h3;
		logic [11:0] h4;
		logic [11:0] h5;
		logic [7:0]  h6;
		logic        p_en;
		logic        h_en;
	} cal_t;

	typedef struct packed {
		logic [31:0] tf;
		logic [31:0] tc;
		logic [19:0] rawp;
		logic [15:0] rawh;
	} temp_out_t;

	function automatic logic [31:0] sx16_32(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx16_64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sar32(input logic [31:0] v, input int s);
		logic signed [31:0] r;
		r = $signed(v) >>> s;
		return r;
	endfunction

	function automatic logic [63:0] sar64(input logic [63:0] v, input int s);
		logic signed [63:0] r;
		r = $signed(v) >>> s;
		return r;
	endfunction

	// Signed 33 x 33 product, low 64 bits.
	function automatic logic [63:0] mul_s33(input logic [32:0] a, input logic [32:0] b);
		logic signed [65:0] f;
		f = $signed(a) * $signed(b);
		return f[63:0];
	endfunction

	// Signed 33 x 16 product, sign extended to 64 bits.
	function automatic logic [63:0] mul33s16(input logic [32:0] a, input logic [15:0] b);
		logic signed [48:0] f;
		f = $signed(a) * $signed(b);
		return {{15{f[48]}}, f};
	endfunction

	// 64-bit value times a signed 16-bit word, low 64 bits.
	function automatic logic [63:0] mul64s16(input logic [63:0] a, input logic [15:0] b);
		logic signed [79:0] f;
		f = $signed(a) * $signed(b);
		return f[63:0];
	endfunction

	// 64-bit value times an unsigned 16-bit word, low 64 bits.
	function automatic logic [63:0] mul64u16(input logic [63:0] a, input logic [15:0] b);
		logic signed [80:0] f;
		f = $signed(a) * $signed({1'b0, b});
		return f[63:0];
	endfunction

endpackage

### hw/rtl/esc_temp.sv
module esc_temp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [19:0]       raw_pressure,
	input  logic [19:0]       raw_temperature,
	input  logic [15:0]       raw_humidity,
	input  esc_pkg::cal_t     cal,
	output logic              out_valid,
	output esc_pkg::temp_out_t res
);

	logic [4:0]  vld_s;
	logic [31:0] a_s1, d_s1, pa_s2, dd_s2, xv_s3, q_s3, tf_s4, tf_s5, tc_s5;
	logic [19:0] rawp_s [1:5];
	logic [15:0] rawh_s [1:5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= {15'd0, raw_temperature[19:3]} - {15'd0, cal.t1, 1'b0};
			d_s1  <= {16'd0, raw_temperature[19:4]} - {16'd0, cal.t1};
			pa_s2 <= a_s1 * esc_pkg::sx16_32(cal.t2);
			dd_s2 <= d_s1 * d_s1;
			xv_s3 <= esc_pkg::sar32(pa_s2, 11);
			q_s3  <= esc_pkg::sar32(dd_s2, 12) * esc_pkg::sx16_32(cal.t3);
			tf_s4 <= xv_s3 + esc_pkg::sar32(q_s3, 14);
			tf_s5 <= tf_s4;
			tc_s5 <= esc_pkg::sar32(tf_s4 * 32'd5 + 32'd128, 8);
			rawp_s[1] <= raw_pressure;
			rawh_s[1] <= raw_humidity;
			for (int i = 2; i <= 5; i++) begin
				rawp_s[i] <= rawp_s[i-1];
				rawh_s[i] <= rawh_s[i-1];
			end
		end
	end

	assign out_valid = vld_s[4];

	always_comb begin
		res.tf   = tf_s5;
		res.tc   = tc_s5;
		res.rawp = rawp_s[5];
		res.rawh = rawh_s[5];
	end

endmodule

### hw/rtl/esc_div.sv
module esc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        out_valid,
	output logic [63:0] quo,
	output logic        zero
);

	// One quotient bit per stage, restoring, on magnitudes.
	logic [65:0] vld_s;
	logic [63:0] rem_s  [0:64];
	logic [63:0] wrk_s  [0:64];
	logic [63:0] dvs_s  [0:64];
	logic        neg_s  [0:64];
	logic        zero_s [0:64];
	logic [63:0] quo_s65;
	logic        zero_s65;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[64:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			wrk_s[0]  <= num[63] ? 64'd0 - num : num;
			dvs_s[0]  <= den[63] ? 64'd0 - den : den;
			neg_s[0]  <= num[63] ^ den[63];
			zero_s[0] <= (den == 64'd0);
		end
	end

	for (genvar gi = 0; gi < 64; gi++) begin : g_step
		logic [64:0] trial;
		logic [64:0] diff;
		assign trial = {rem_s[gi], wrk_s[gi][63]};
		assign diff  = trial - {1'b0, dvs_s[gi]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[gi+1]  <= diff[64] ? trial[63:0] : diff[63:0];
				wrk_s[gi+1]  <= {wrk_s[gi][62:0], ~diff[64]};
				dvs_s[gi+1]  <= dvs_s[gi];
				neg_s[gi+1]  <= neg_s[gi];
				zero_s[gi+1] <= zero_s[gi];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s65  <= neg_s[64] ? 64'd0 - wrk_s[64] : wrk_s[64];
			zero_s65 <= zero_s[64];
		end
	end

	assign out_valid = vld_s[65];
	assign quo       = quo_s65;
	assign zero      = zero_s65;

endmodule

### hw/rtl/esc_press.sv
module esc_press (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  esc_pkg::temp_out_t tin,
	input  esc_pkg::cal_t      cal,
	output logic               out_valid,
	output logic [31:0]        pressure
);

	logic [5:0]  pre_vld_s;
	logic [5:0]  post_vld_s;
	logic [32:0] x_s1;
	logic [19:0] rawp_s1, rawp_s2, rawp_s3, rawp_s4;
	logic [63:0] xx_s2, xp5_s2, xp2_s2;
	logic [63:0] y6_s3, xx3_s3, xp5_s3, xp2_s3;
	logic [63:0] y_s4, xs_s4, m_s5, n1_s5, dv_s6, num_s6;
	logic        dvld;
	logic [63:0] quo;
	logic        dzero;
	logic [63:0] p_s7, s_s7, pa8_s7;
	logic [63:0] p_s8, s_s8, pa8_s8, a1_s8;
	logic [63:0] p_s9, m0_s9, b_s9;
	logic [31:0] m1_s9, m2_s9;
	logic [63:0] p_s10, prod_s10, b_s10, sum_s11;
	logic [31:0] res_s12;
	logic        z_s7, z_s8, z_s9, z_s10, z_s11;
	logic [63:0] fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s  <= '0;
			post_vld_s <= '0;
		end else if (en) begin
			pre_vld_s  <= {pre_vld_s[4:0], in_valid};
			post_vld_s <= {post_vld_s[4:0], dvld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= {tin.tf[31], tin.tf} - 33'd128000;
			rawp_s1 <= tin.rawp;
			xx_s2   <= esc_pkg::mul_s33(x_s1, x_s1);
			xp5_s2  <= esc_pkg::mul33s16(x_s1, cal.p5);
			xp2_s2  <= esc_pkg::mul33s16(x_s1, cal.p2);
			rawp_s2 <= rawp_s1;
			y6_s3   <= esc_pkg::mul64s16(xx_s2, cal.p6);
			xx3_s3  <= esc_pkg::mul64s16(xx_s2, cal.p3);
			xp5_s3  <= xp5_s2;
			xp2_s3  <= xp2_s2;
			rawp_s3 <= rawp_s2;
			y_s4    <= y6_s3 + (xp5_s3 << 17) + (esc_pkg::sx16_64(cal.p4) << 35);
			xs_s4   <= esc_pkg::sar64(xx3_s3, 8) + (xp2_s3 << 12);
			rawp_s4 <= rawp_s3;
			m_s5    <= esc_pkg::mul64u16(esc_pkg::P_OFFS + xs_s4, cal.p1);
			n1_s5   <= ((64'd1048576 - {44'd0, rawp_s4}) << 31) - y_s4;
			dv_s6   <= esc_pkg::sar64(m_s5, 33);
			num_s6  <= n1_s5 * 64'd3125;
		end
	end

	esc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pre_vld_s[5]),
		.num       (num_s6),
		.den       (dv_s6),
		.out_valid (dvld),
		.quo       (quo),
		.zero      (dzero)
	);

	assign fin = esc_pkg::sar64(sum_s11, 8) + (esc_pkg::sx16_64(cal.p7) << 4);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s7     <= quo;
			s_s7     <= esc_pkg::sar64(quo, 13);
			pa8_s7   <= esc_pkg::mul64s16(quo, cal.p8);
			z_s7     <= dzero;
			a1_s8    <= esc_pkg::mul64s16(s_s7, cal.p9);
			s_s8     <= s_s7;
			p_s8     <= p_s7;
			pa8_s8   <= pa8_s7;
			z_s8     <= z_s7;
			m0_s9    <= a1_s8[31:0] * s_s8[31:0];
			m1_s9    <= a1_s8[31:0] * s_s8[63:32];
			m2_s9    <= a1_s8[63:32] * s_s8[31:0];
			p_s9     <= p_s8;
			b_s9     <= esc_pkg::sar64(pa8_s8, 19);
			z_s9     <= z_s8;
			prod_s10 <= m0_s9 + {m1_s9 + m2_s9, 32'd0};
			p_s10    <= p_s9;
			b_s10    <= b_s9;
			z_s10    <= z_s9;
			sum_s11  <= p_s10 + esc_pkg::sar64(prod_s10, 25) + b_s10;
			z_s11    <= z_s10;
			res_s12  <= (z_s11 || !cal.p_en) ? 32'd0 : fin[31:0];
		end
	end

	assign out_valid = post_vld_s[5];
	assign pressure  = res_s12;

endmodule

### hw/rtl/esc_hum.sv
module esc_hum (
	input  logic               clk,
	input  logic               en,
	input  esc_pkg::temp_out_t tin,
	input  esc_pkg::cal_t      cal,
	output logic [16:0]        humidity
);

	logic [31:0] x_s1, c_s1;
	logic [31:0] c_s2, h5x_s2, x6p_s2, x4p_s2;
	logic [31:0] x1_s3, x3_s3, x4_s3;
	logic [31:0] x2_s4, x5p_s4;
	logic [31:0] x2_s5, t_s5;
	logic [31:0] v_s6, v_s7, ss_s7, v_s8, w_s8;
	logic [16:0] hum_s9;
	logic [31:0] v2;

	assign v2 = v_s8 - esc_pkg::sar32(w_s8, 4);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= tin.tf - 32'd76800;
			c_s1   <= {2'b00, tin.rawh, 14'd0} - {cal.h4, 20'd0};
			c_s2   <= c_s1;
			h5x_s2 <= {{20{cal.h5[11]}}, cal.h5} * x_s1;
			x6p_s2 <= x_s1 * {{24{cal.h6[7]}}, cal.h6};
			x4p_s2 <= x_s1 * {24'd0, cal.h3};
			x1_s3  <= c_s2 - h5x_s2;
			x3_s3  <= esc_pkg::sar32(x6p_s2, 10);
			x4_s3  <= esc_pkg::sar32(x4p_s2, 11);
			x2_s4  <= esc_pkg::sar32(x1_s3 + 32'd16384, 15);
			x5p_s4 <= x3_s3 * (x4_s3 + 32'd32768);
			x2_s5  <= x2_s4;
			t_s5   <= (esc_pkg::sar32(x5p_s4, 10) + 32'd2097152) * esc_pkg::sx16_32(cal.h2)
				+ 32'd8192;
			v_s6   <= x2_s5 * esc_pkg::sar32(t_s5, 14);
			v_s7   <= v_s6;
			ss_s7  <= esc_pkg::sar32(v_s6, 15) * esc_pkg::sar32(v_s6, 15);
			v_s8   <= v_s7;
			w_s8   <= esc_pkg::sar32(ss_s7, 7) * {24'd0, cal.h1};
			priority if (!cal.h_en || v2[31]) begin
				hum_s9 <= '0;
			end else if (v2 > esc_pkg::HUM_CLIP) begin
				hum_s9 <= esc_pkg::HUM_MAX;
			end else begin
				hum_s9 <= v2[28:12];
			end
		end
	end

	assign humidity = hum_s9;

endmodule

### hw/rtl/environment_sensor_compensation.sv
// From an accepted input beat to its result beat the pipeline runs through 5
// temperature stages, then 78 pressure stages including a 66-stage radix-2 divider.
// Throughput: one sample set per cycle; the whole pipeline holds only while a
// finished beat waits in the last stage and out_stall is high.
// Reset clears all valid bits, sets every calibration register to zero and both
// enables to one. Datapath registers are not reset.
module environment_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        raw_pressure,
	input  logic [19:0]        raw_temperature,
	input  logic [15:0]        raw_humidity,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temp_centi,
	output logic [31:0]        pressure_q24_8,
	output logic [16:0]        humidity_q22_10,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	// Calibration words, held in their unpacked form.
	esc_pkg::cal_t      cal_q;
	esc_pkg::temp_out_t tout;
	logic               tvld;
	logic               en;
	logic [16:0]        hum;

	// Temperature travels alongside the full pressure pipeline, humidity alongside
	// the part of it that its own shorter pipeline does not cover.
	logic [31:0] tc_pipe_s  [0:esc_pkg::PRESS_LAT-1];
	logic [16:0] hum_pipe_s [0:esc_pkg::PRESS_LAT-esc_pkg::HUM_LAT-1];

	// The pipeline moves as a whole: it advances unless a finished beat sits in
	// the last stage and the receiver stalls it.
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Register writes are always taken. Each write masks the data to the
	// register's own field layout.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '{p_en: 1'b1, h_en: 1'b1, default: '0};
		end else if (cfg_valid) begin
			unique case (esc_pkg::cfg_reg_t'(cfg_index))
				esc_pkg::REG_CAL_TEMP: begin
					cal_q.t1 <= cfg_data[15:0];
					cal_q.t2 <= cfg_data[31:16];
					cal_q.t3 <= cfg_data[47:32];
				end
				esc_pkg::REG_CAL_PRESS_A: begin
					cal_q.p1 <= cfg_data[15:0];
					cal_q.p2 <= cfg_data[31:16];
					cal_q.p3 <= cfg_data[47:32];
				end
				esc_pkg::REG_CAL_PRESS_B: begin
					cal_q.p4 <= cfg_data[15:0];
					cal_q.p5 <= cfg_data[31:16];
					cal_q.p6 <= cfg_data[47:32];
				end
				esc_pkg::REG_CAL_PRESS_C: begin
					cal_q.p7 <= cfg_data[15:0];
					cal_q.p8 <= cfg_data[31:16];
					cal_q.p9 <= cfg_data[47:32];
				end
				esc_pkg::REG_CAL_HUM_A: begin
					cal_q.h1 <= cfg_data[7:0];
					cal_q.h2 <= cfg_data[23:8];
					cal_q.h3 <= cfg_data[31:24];
				end
				esc_pkg::REG_CAL_HUM_B: begin
					cal_q.h4 <= cfg_data[11:0];
					cal_q.h5 <= cfg_data[23:12];
					cal_q.h6 <= cfg_data[31:24];
				end
				esc_pkg::REG_PRESS_EN: begin
					cal_q.p_en <= cfg_data[0];
				end
				esc_pkg::REG_HUM_EN: begin
					cal_q.h_en <= cfg_data[0];
				end
			endcase
		end
	end

	// Fine temperature and centi-degrees; raw pressure and humidity ride along.
	esc_temp u_temp (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (in_valid),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.raw_humidity    (raw_humidity),
		.cal             (cal_q),
		.out_valid       (tvld),
		.res             (tout)
	);

	// Pressure polynomial, signed division and final correction. Its valid bit
	// is the valid of the output beat.
	esc_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (tvld),
		.tin       (tout),
		.cal       (cal_q),
		.out_valid (out_valid),
		.pressure  (pressure_q24_8)
	);

	// Relative humidity with its clamp.
	esc_hum u_hum (
		.clk      (clk),
		.en       (en),
		.tin      (tout),
		.cal      (cal_q),
		.humidity (hum)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			tc_pipe_s[0]  <= tout.tc;
			hum_pipe_s[0] <= hum;
			for (int i = 1; i < esc_pkg::PRESS_LAT; i++) begin
				tc_pipe_s[i] <= tc_pipe_s[i-1];
			end
			for (int i = 1; i < esc_pkg::PRESS_LAT - esc_pkg::HUM_LAT; i++) begin
				hum_pipe_s[i] <= hum_pipe_s[i-1];
			end
		end
	end

	assign temp_centi      = tc_pipe_s[esc_pkg::PRESS_LAT-1];
	assign humidity_q22_10 = hum_pipe_s[esc_pkg::PRESS_LAT-esc_pkg::HUM_LAT-1];

endmodule
